/* rtl/swsu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsu_pkg: shared types and codes of the SIMD warp shader unit
// Command and result word layouts, opcodes, trap codes and fixed widths.
// ----------------------------------------------------------------------------
package swsu_pkg;

  localparam int ADDR_W  = 19;
  localparam int COLOR_W = 32;
  localparam int PC_W    = 11;
  localparam int OP_W    = 4;
  localparam int REG_W   = 4;
  localparam int IMM_W   = 16;

  localparam logic [PC_W-1:0] PROG_LENGTH_RESET = 11'd1024;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_EXEC  = 1'b1;

  localparam logic [OP_W-1:0] OP_MOVLO = 4'd0;
  localparam logic [OP_W-1:0] OP_MOVHI = 4'd1;
  localparam logic [OP_W-1:0] OP_ADD   = 4'd2;
  localparam logic [OP_W-1:0] OP_MUL   = 4'd3;
  localparam logic [OP_W-1:0] OP_DIV   = 4'd4;
  localparam logic [OP_W-1:0] OP_SLT   = 4'd5;
  localparam logic [OP_W-1:0] OP_STORE = 4'd6;
  localparam logic [OP_W-1:0] OP_END   = 4'd7;

  localparam logic [1:0] TRAP_PC   = 2'd0;
  localparam logic [1:0] TRAP_OP   = 2'd1;
  localparam logic [1:0] TRAP_DEST = 2'd2;
  localparam logic [1:0] TRAP_SRC  = 2'd3;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_TRAP  = 1'b1;

  typedef struct packed {
    logic              action;
    logic [ADDR_W-1:0] warp_start;
    logic [OP_W-1:0]   opcode;
    logic [REG_W-1:0]  dst_index;
    logic [IMM_W-1:0]  operand_value;
  } cmd_t;

  typedef struct packed {
    logic               kind;
    logic [ADDR_W-1:0]  pixel_address;
    logic [COLOR_W-1:0] pixel_color;
    logic [1:0]         trap_code;
    logic               last;
  } res_t;

endpackage

/* rtl/simd_warp_shader_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simd_warp_shader_unit: SIMD shader unit, one instruction over all lanes
// Lane registers sit in RAM, lanes are processed one after another.
// ----------------------------------------------------------------------------
// Start: serial coordinate divide, then states INITX and INITY per lane.
// Move, add, slt: READ and OP per lane. Mul, div: READ, OP and ALU per lane,
// the ALU state waiting on the bit-serial unit. Store: READ and STORE per lane,
// held under output stall. Trap report: state TRAP, held under output stall;
// end or ignored word: handled in IDLE. One word is in flight at a time.
// Reset clears control state and row valid bits; rows read as zero until written.
// ----------------------------------------------------------------------------
module simd_warp_shader_unit
  import swsu_pkg::*;
#(
  parameter int SCREEN_WIDTH   = 640,
  parameter int SCREEN_HEIGHT  = 480,
  parameter int REGISTER_COUNT = 9,
  parameter int LANE_COUNT     = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  cmd_t            cmd,
  output logic            res_valid,
  input  logic            res_stall,
  output res_t            res,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [PC_W-1:0] cfg_data
);

  localparam int LW    = (LANE_COUNT > 1) ? $clog2(LANE_COUNT) : 1;
  localparam int RW    = $clog2(REGISTER_COUNT);
  localparam int DEPTH = REGISTER_COUNT * LANE_COUNT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
  localparam int YW    = ADDR_W + 1;
  localparam logic [24:0] SCREEN_PIXELS = 25'(SCREEN_WIDTH * SCREEN_HEIGHT);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_COORD = 4'd1;
  localparam logic [3:0] S_INITX = 4'd2;
  localparam logic [3:0] S_INITY = 4'd3;
  localparam logic [3:0] S_TRAP  = 4'd4;
  localparam logic [3:0] S_READ  = 4'd5;
  localparam logic [3:0] S_OP    = 4'd6;
  localparam logic [3:0] S_ALU   = 4'd7;
  localparam logic [3:0] S_STORE = 4'd8;

  function automatic logic [AW-1:0] rf_addr(logic [RW-1:0] row, logic [LW-1:0] ln);
    return AW'(int'(row) * LANE_COUNT + int'(ln));
  endfunction

  logic [3:0]                state;
  logic [PC_W-1:0]           prog_length;
  logic [PC_W-1:0]           pc;
  logic                      running;
  logic                      trap_seen;
  logic [ADDR_W-1:0]         warp_base;
  logic [REGISTER_COUNT-1:0] row_valid;
  logic [OP_W-1:0]           op_r;
  logic [RW-1:0]             d_r;
  logic [RW-1:0]             v_r;
  logic [IMM_W-1:0]          imm_r;
  logic [1:0]                trap_code_r;
  logic [LW-1:0]             lane;
  logic [XW-1:0]             x_r;
  logic [YW-1:0]             y_r;

  logic       accept;
  logic       out_free;
  logic       res_load;
  logic       trap_any;
  logic [1:0] trap_code;
  logic       op_writes;
  logic       op_reads;
  logic       lane_last;
  logic       muldiv;

  logic                      coord_start;
  logic                      coord_done;
  logic [ADDR_W-1:0]         coord_quot;
  logic [XW-1:0]             coord_rem;

  logic                      alu_start;
  logic                      alu_busy;
  logic                      alu_done;
  logic [COLOR_W-1:0]        alu_result;

  logic                      rf_we;
  logic [RW-1:0]             rf_wrow;
  logic [AW-1:0]             rf_waddr;
  logic [COLOR_W-1:0]        rf_wdata;
  logic [RW-1:0]             a_row;
  logic [COLOR_W-1:0]        qa;
  logic [COLOR_W-1:0]        qb;
  logic [COLOR_W-1:0]        opa;
  logic [COLOR_W-1:0]        opb;
  logic [COLOR_W-1:0]        simple_res;

  logic [YW-1:0]             pix_addr;
  logic                      on_screen;
  logic                      next_off;

  assign cfg_ready = 1'b1;
  assign cmd_stall = (state != S_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign out_free  = !res_valid || !res_stall;
  assign lane_last = (lane == LW'(LANE_COUNT - 1));
  assign muldiv    = (op_r == OP_MUL) || (op_r == OP_DIV);
  assign res_load  = out_free && ((state == S_TRAP) || ((state == S_STORE) && on_screen));

  // instruction checks in priority order
  always_comb begin
    op_writes = !cmd.opcode[OP_W-1] && !(cmd.opcode inside {OP_STORE, OP_END});
    op_reads  = cmd.opcode inside {[OP_ADD:OP_SLT]};
    trap_any  = 1'b1;
    trap_code = TRAP_PC;
    if (pc >= prog_length) begin
      trap_code = TRAP_PC;
    end else if (cmd.opcode[OP_W-1]) begin
      trap_code = TRAP_OP;
    end else if (op_writes && ({1'b0, cmd.dst_index} >= 5'(REGISTER_COUNT))) begin
      trap_code = TRAP_DEST;
    end else if (op_reads && (cmd.operand_value >= IMM_W'(REGISTER_COUNT))) begin
      trap_code = TRAP_SRC;
    end else begin
      trap_any = 1'b0;
    end
  end

  assign coord_start = accept && (cmd.action == ACT_START);

  swsu_coord #(
    .SCREEN_WIDTH (SCREEN_WIDTH)
  ) u_coord (
    .clk      (clk),
    .rst      (rst),
    .start    (coord_start),
    .dividend (cmd.warp_start),
    .done     (coord_done),
    .quot     (coord_quot),
    .rem      (coord_rem)
  );

  // register file read: port A holds the destination (R0 on store), B the source
  assign a_row = (op_r == OP_STORE) ? '0 : d_r;

  swsu_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (DEPTH)
  ) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rf_addr(a_row, lane)),
    .rdata (qa)
  );

  swsu_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (DEPTH)
  ) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .raddr (rf_addr(v_r, lane)),
    .rdata (qb)
  );

  // a row not written since start reads as zero
  assign opa = row_valid[a_row] ? qa : '0;
  assign opb = row_valid[v_r] ? qb : '0;

  always_comb begin
    case (op_r)
      OP_MOVLO: simple_res = (opa & 32'hFFFF0000) | {16'h0000, imm_r};
      OP_MOVHI: simple_res = (opa & 32'h0000FFFF) | {imm_r, 16'h0000};
      OP_ADD:   simple_res = opa + opb;
      OP_SLT:   simple_res = {{(COLOR_W-1){1'b0}}, opa < opb};
      default:  simple_res = opa;
    endcase
  end

  assign alu_start = (state == S_OP) && muldiv;

  swsu_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .start  (alu_start),
    .op_div (op_r == OP_DIV),
    .a      (opa),
    .b      (opb),
    .busy   (alu_busy),
    .done   (alu_done),
    .result (alu_result)
  );

  always_comb begin
    rf_we    = 1'b0;
    rf_wrow  = d_r;
    rf_wdata = simple_res;
    case (state)
      S_INITX: begin
        rf_we    = 1'b1;
        rf_wrow  = RW'(1);
        rf_wdata = COLOR_W'(x_r);
      end
      S_INITY: begin
        rf_we    = 1'b1;
        rf_wrow  = RW'(2);
        rf_wdata = COLOR_W'(y_r);
      end
      S_OP: begin
        rf_we = !muldiv;
      end
      S_ALU: begin
        rf_we    = alu_done;
        rf_wdata = alu_result;
      end
      default: rf_we = 1'b0;
    endcase
  end

  assign rf_waddr = rf_addr(rf_wrow, lane);

  // lanes on screen form a prefix of the warp
  assign pix_addr  = {1'b0, warp_base} + YW'(lane);
  assign on_screen = (25'(pix_addr) < SCREEN_PIXELS);
  assign next_off  = ((25'(pix_addr) + 25'd1) >= SCREEN_PIXELS);

  always_ff @(posedge clk) begin
    if (rst) begin
      prog_length <= PROG_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      prog_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pc        <= '0;
      running   <= 1'b0;
      trap_seen <= 1'b0;
      warp_base <= '0;
      row_valid <= '0;
      res_valid <= 1'b0;
      lane      <= '0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (cmd.action == ACT_START) begin
              warp_base <= cmd.warp_start;
              row_valid <= '0;
              pc        <= '0;
              running   <= 1'b1;
              state     <= S_COORD;
            end else if (running) begin
              if (trap_any) begin
                running <= 1'b0;
                if (!trap_seen) begin
                  trap_seen   <= 1'b1;
                  trap_code_r <= trap_code;
                  state       <= S_TRAP;
                end
              end else begin
                pc <= pc + 1'b1;
                if (cmd.opcode == OP_END) begin
                  running <= 1'b0;
                end else begin
                  op_r  <= cmd.opcode;
                  d_r   <= cmd.dst_index[RW-1:0];
                  v_r   <= cmd.operand_value[RW-1:0];
                  imm_r <= cmd.operand_value;
                  lane  <= '0;
                  state <= S_READ;
                end
              end
            end
          end
        end
        S_COORD: begin
          if (coord_done) begin
            x_r   <= coord_rem;
            y_r   <= YW'(coord_quot);
            lane  <= '0;
            state <= S_INITX;
          end
        end
        S_INITX: begin
          state <= S_INITY;
        end
        S_INITY: begin
          // step the screen cursor to the next lane
          if (x_r == XW'(SCREEN_WIDTH - 1)) begin
            x_r <= '0;
            y_r <= y_r + 1'b1;
          end else begin
            x_r <= x_r + 1'b1;
          end
          if (lane_last) begin
            row_valid[1] <= 1'b1;
            row_valid[2] <= 1'b1;
            state        <= S_IDLE;
          end else begin
            lane  <= lane + 1'b1;
            state <= S_INITX;
          end
        end
        S_TRAP: begin
          if (out_free) begin
            res.kind          <= KIND_TRAP;
            res.pixel_address <= '0;
            res.pixel_color   <= '0;
            res.trap_code     <= trap_code_r;
            res.last          <= 1'b1;
            state             <= S_IDLE;
          end
        end
        S_READ: begin
          state <= (op_r == OP_STORE) ? S_STORE : S_OP;
        end
        S_OP: begin
          if (muldiv) begin
            state <= S_ALU;
          end else if (lane_last) begin
            row_valid[d_r] <= 1'b1;
            state          <= S_IDLE;
          end else begin
            lane  <= lane + 1'b1;
            state <= S_READ;
          end
        end
        S_ALU: begin
          if (alu_done) begin
            if (lane_last) begin
              row_valid[d_r] <= 1'b1;
              state          <= S_IDLE;
            end else begin
              lane  <= lane + 1'b1;
              state <= S_READ;
            end
          end
        end
        S_STORE: begin
          if (!on_screen) begin
            // drop the rest of the warp, it lies past the screen
            state <= S_IDLE;
          end else if (out_free) begin
            res.kind          <= KIND_PIXEL;
            res.pixel_address <= pix_addr[ADDR_W-1:0];
            res.pixel_color   <= opa;
            res.trap_code     <= TRAP_PC;
            res.last          <= lane_last || next_off;
            if (lane_last) begin
              state <= S_IDLE;
            end else begin
              lane  <= lane + 1'b1;
              state <= S_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_trap_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.kind == KIND_TRAP)) |-> res.last)
    else $error("trap word without last");

  a_trap_sticky: assert property (@(posedge clk) disable iff (rst)
    trap_seen |=> trap_seen)
    else $error("trap_seen cleared outside reset");

  a_alu_idle: assert property (@(posedge clk) disable iff (rst)
    alu_start |-> !alu_busy)
    else $error("alu started while busy");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_TRAP) |-> !(res_valid && (res.kind == KIND_TRAP) && !res_stall && trap_seen
      && $past(state) == S_IDLE && $past(trap_seen)))
    else $error("second trap word emitted");

endmodule

/* rtl/swsu_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsu_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module swsu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 288,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/swsu_coord.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsu_coord: bit-serial divide of the warp base by the screen width
// Restoring division, one quotient bit per cycle, giving base x and y.
// ----------------------------------------------------------------------------
module swsu_coord
  import swsu_pkg::*;
#(
  parameter int SCREEN_WIDTH = 640,
  localparam int XW = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1,
  localparam int CW = $clog2(ADDR_W)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ADDR_W-1:0] dividend,
  output logic              done,
  output logic [ADDR_W-1:0] quot,
  output logic [XW-1:0]     rem
);

  localparam logic [XW:0] DIVISOR = (XW+1)'(SCREEN_WIDTH);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [XW:0]   trial;
  logic          ge;

  assign trial = {rem, quot[ADDR_W-1]};
  assign ge    = (trial >= DIVISOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quot <= dividend;
        rem  <= '0;
      end else if (busy) begin
        // shift one dividend bit in, subtract when it fits
        rem  <= ge ? XW'(trial - DIVISOR) : trial[XW-1:0];
        quot <= {quot[ADDR_W-2:0], ge};
        cnt  <= cnt + 1'b1;
        if (cnt == CW'(ADDR_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/swsu_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swsu_alu: bit-serial multiply and divide unit
// Shift-add multiply (low word) and restoring unsigned divide, one bit a cycle.
// ----------------------------------------------------------------------------
module swsu_alu
  import swsu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               op_div,
  input  logic [COLOR_W-1:0] a,
  input  logic [COLOR_W-1:0] b,
  output logic               busy,
  output logic               done,
  output logic [COLOR_W-1:0] result
);

  localparam int CW = $clog2(COLOR_W);

  logic               div_r;
  logic [CW-1:0]      cnt;
  logic [COLOR_W-1:0] acc;
  logic [COLOR_W-1:0] sh;
  logic [COLOR_W-1:0] bb;
  logic [COLOR_W:0]   trial;
  logic               ge;

  assign trial  = {acc, sh[COLOR_W-1]};
  assign ge     = (trial >= {1'b0, bb});
  assign result = div_r ? sh : acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        div_r <= op_div;
        acc   <= '0;
        sh    <= a;
        bb    <= b;
      end else if (busy) begin
        if (div_r) begin
          // a zero divisor leaves every quotient bit set
          acc <= ge ? COLOR_W'(trial - {1'b0, bb}) : trial[COLOR_W-1:0];
          sh  <= {sh[COLOR_W-2:0], ge};
        end else begin
          if (sh[0]) begin
            acc <= acc + bb;
          end
          sh <= sh >> 1;
          bb <= bb << 1;
        end
        cnt <= cnt + 1'b1;
        if (cnt == CW'(COLOR_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
